FILE: rtl/range_encoder_byte_carry_defines.svh
// Assertion macros for the range encoder checks
`ifndef RANGE_ENCODER_BYTE_CARRY_DEFINES_SVH
`define RANGE_ENCODER_BYTE_CARRY_DEFINES_SVH

// Condition must never hold while out of reset
`define RECB_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("range encoder check failed");

// Condition in one cycle forces the consequence in the next
`define RECB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("range encoder check failed");

`endif

FILE: rtl/recb_pkg.sv
// Shared types and constants of the byte range encoder
`timescale 1ns / 1ps
package recb_pkg;

	localparam int unsigned BUF_DEPTH = 14;
	localparam logic [56:0] RENORM_LIMIT = 57'h00_0100_0000_0000;

	typedef struct packed {
		logic [22:0] interval_low;
		logic [23:0] interval_high;
		logic        end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [31:0] repeat_count;
		logic        run_end;
		logic        count_overflow;
	} out_word_t;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_FLUSH_HELD,
		CMD_FLUSH_RUN,
		CMD_EMIT_TOP,
		CMD_ADD_FOLLOW,
		CMD_MASK,
		CMD_FACTOR,
		CMD_MUL_LL,
		CMD_MUL_LH,
		CMD_MUL_DL,
		CMD_MUL_DH,
		CMD_MUL_END,
		CMD_HELD_PLUS1,
		CMD_SHORT_INIT,
		CMD_SHORT_STEP,
		CMD_TAIL,
		CMD_DONE,
		CMD_POP
	} cmd_t;

	typedef struct packed {
		logic width_lt;
		logic diff_zero;
		logic straddle;
		logic short_done;
		logic tail_nz;
		logic eom;
		logic cnt_nz;
		logic last;
	} status_t;

endpackage

FILE: rtl/range_encoder_byte_carry.sv
// Sequence: an accepted item runs renormalisation (pending flush, bytes shifted out or
// followed, loop exits), then the interval update; at end of message the final flush and
// tail bytes follow. Results are buffered and then drained one word a cycle while out_stall
// is low. One item at a time: the 57-bit interval update goes through the shared 24x29
// multiplier (four partial products). Asynchronous active-low reset clears the coder to a
// full interval, shift 16.
`timescale 1ns / 1ps
`include "range_encoder_byte_carry_defines.svh"
module range_encoder_byte_carry import recb_pkg::*; #(
	parameter int FOLLOW_COUNT_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_data,
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data
);

	cmd_t    cmd;
	status_t status;

	recb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	recb_dpath #(.FOLLOW_COUNT_BITS(FOLLOW_COUNT_BITS)) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_data    (in_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.status     (status),
		.out_data   (out_data)
	);

	// Input is only taken with no result word pending
	`RECB_ASSERT_NEVER(a_no_overlap, out_valid && !in_stall)
	// An accepted item keeps the input closed for the next cycle
	`RECB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// The last word of an item closes the output
	`RECB_ASSERT_NEXT(a_drain_ends, out_valid && !out_stall && out_data.run_end, !out_valid)

endmodule

FILE: rtl/recb_dpath.sv
// Datapath: coder registers, shared multiplier and result word buffer
`timescale 1ns / 1ps
module recb_dpath import recb_pkg::*; #(
	parameter int FOLLOW_COUNT_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  in_word_t  in_data,
	input  logic      cfg_wr_en,
	input  logic [4:0] cfg_wr_data,
	output status_t   status,
	output out_word_t out_data
);

	localparam int FCB = FOLLOW_COUNT_BITS;
	localparam int RW = (FCB > 32) ? FCB : 33;

	logic [56:0] base_q, width_q, factor_q;
	logic [FCB-1:0] pend_q;
	logic [7:0] held_q;
	logic ovf_q, drain_ovf_q, eom_q;
	logic [4:0] shift_q, sh_q;
	logic [22:0] lo_q;
	logic [23:0] d_q;
	logic [52:0] prod_q;
	logic [55:0] cand_q;
	logic [2:0] k_q;
	logic [3:0] cnt_q, rd_q;
	logic [7:0] buf_byte_q [BUF_DEPTH];
	logic [31:0] buf_rep_q [BUF_DEPTH];

	logic [57:0] top_hi, xr;
	logic [55:0] cand_nxt;
	logic [4:0] sh_c;
	logic [23:0] total, hi_c, lo_c;
	logic [23:0] mul_a;
	logic [28:0] mul_b;
	logic [52:0] prod;
	logic em_en, em_wr, clip;
	logic [7:0] em_byte;
	logic [FCB-1:0] em_rep;
	logic [RW-1:0] rep_ext;
	logic [31:0] rep_out;

	// Upper bound of the interval and agreement of the top bytes
	assign top_hi = {1'b0, base_q} + {1'b0, width_q} - 58'd1;
	assign xr = {1'b0, base_q} ^ top_hi;
	assign cand_nxt = cand_q | (top_hi[55:0] & (56'hFF << {k_q, 3'b000}));

	assign status.width_lt = width_q < RENORM_LIMIT;
	assign status.diff_zero = (xr[57:48] == 10'd0);
	assign status.straddle = xr[56];
	assign status.short_done = (cand_nxt >= base_q[55:0]) || (k_q == 3'd0);
	assign status.tail_nz = (cand_q != 56'd0);
	assign status.eom = eom_q;
	assign status.cnt_nz = (cnt_q != 4'd0);
	assign status.last = (rd_q == cnt_q - 4'd1);

	// Clamp the incoming symbol against the cumulative total
	always_comb begin
		if (shift_q < 5'd2) sh_c = 5'd2;
		else if (shift_q > 5'd23) sh_c = 5'd23;
		else sh_c = shift_q;
		total = 24'd1 << sh_c;
		hi_c = (in_data.interval_high > total) ? total : in_data.interval_high;
		if (hi_c == 24'd0) hi_c = 24'd1;
		lo_c = ({1'b0, in_data.interval_low} >= hi_c) ? hi_c - 24'd1
			: {1'b0, in_data.interval_low};
	end

	// Select multiplier operands by partial product
	always_comb begin
		mul_a = ((cmd == CMD_MUL_DL) || (cmd == CMD_MUL_DH)) ? d_q : {1'b0, lo_q};
		mul_b = ((cmd == CMD_MUL_LH) || (cmd == CMD_MUL_DH)) ? {1'b0, factor_q[56:29]}
			: factor_q[28:0];
		prod = 53'(mul_a) * 53'(mul_b);
	end

	// Pick the run word to record
	always_comb begin
		em_en = 1'b0;
		em_byte = 8'h00;
		em_rep = FCB'(1);
		case (cmd)
			CMD_FLUSH_HELD: begin
				em_en = (pend_q != '0);
				em_byte = held_q + {7'd0, base_q[56]};
			end
			CMD_FLUSH_RUN: begin
				em_en = (pend_q > FCB'(1));
				em_byte = base_q[56] ? 8'h00 : 8'hFF;
				em_rep = pend_q - FCB'(1);
			end
			CMD_EMIT_TOP: begin
				em_en = 1'b1;
				em_byte = base_q[55:48];
			end
			CMD_HELD_PLUS1: begin
				em_en = (pend_q != '0);
				em_byte = held_q + 8'd1;
			end
			CMD_TAIL: begin
				em_en = 1'b1;
				em_byte = cand_q[55:48];
			end
			default: em_en = 1'b0;
		endcase
		em_wr = em_en && (cnt_q < 4'(BUF_DEPTH));
		rep_ext = RW'(em_rep);
		clip = rep_ext > RW'(33'h0_FFFF_FFFF);
		rep_out = clip ? 32'hFFFF_FFFF : rep_ext[31:0];
	end

	// Advance the coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			width_q <= 57'd1 << 56;
			pend_q <= '0;
			held_q <= '0;
			ovf_q <= 1'b0;
			drain_ovf_q <= 1'b0;
			shift_q <= 5'd16;
			cnt_q <= '0;
			rd_q <= '0;
		end else begin
			if (cfg_wr_en) shift_q <= cfg_wr_data;
			case (cmd)
				CMD_LOAD: cnt_q <= '0;
				CMD_FLUSH_RUN: pend_q <= '0;
				CMD_EMIT_TOP: begin
					base_q <= {1'b0, base_q[47:0], 8'h00};
					width_q <= width_q << 8;
				end
				CMD_ADD_FOLLOW: begin
					if (pend_q == '0) held_q <= base_q[55:48];
					if (pend_q == '1) ovf_q <= 1'b1;
					else pend_q <= pend_q + FCB'(1);
					base_q <= base_q << 8;
					width_q <= width_q << 8;
				end
				CMD_MASK: base_q[56] <= 1'b0;
				CMD_MUL_LH: base_q <= base_q + 57'(prod_q);
				CMD_MUL_DL: base_q <= base_q + (57'(prod_q) << 29);
				CMD_MUL_DH: width_q <= 57'(prod_q);
				CMD_MUL_END: width_q <= width_q + (57'(prod_q) << 29);
				CMD_DONE: begin
					drain_ovf_q <= ovf_q;
					rd_q <= '0;
					if (eom_q) begin
						base_q <= '0;
						width_q <= 57'd1 << 56;
						pend_q <= '0;
						held_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				CMD_POP: rd_q <= rd_q + 4'd1;
				default: ;
			endcase
			if (em_wr) begin
				cnt_q <= cnt_q + 4'd1;
				if (clip) ovf_q <= 1'b1;
			end
		end
	end

	// Hold symbol operands, products and the tail candidate
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				lo_q <= lo_c[22:0];
				d_q <= hi_c - lo_c;
				eom_q <= in_data.end_of_message;
				sh_q <= sh_c;
			end
			CMD_FACTOR: factor_q <= width_q >> sh_q;
			CMD_MUL_LL, CMD_MUL_LH, CMD_MUL_DL, CMD_MUL_DH: prod_q <= prod;
			CMD_SHORT_INIT: begin
				cand_q <= '0;
				k_q <= 3'd6;
			end
			CMD_SHORT_STEP: begin
				cand_q <= cand_nxt;
				k_q <= k_q - 3'd1;
			end
			CMD_TAIL: cand_q <= cand_q << 8;
			default: k_q <= k_q;
		endcase
	end

	// Record run words
	always_ff @(posedge clk) begin
		if (em_wr) begin
			buf_byte_q[cnt_q] <= em_byte;
			buf_rep_q[cnt_q] <= rep_out;
		end
	end

	assign out_data.out_byte = buf_byte_q[rd_q];
	assign out_data.repeat_count = buf_rep_q[rd_q];
	assign out_data.run_end = status.last;
	assign out_data.count_overflow = drain_ovf_q;

endmodule

FILE: rtl/recb_ctrl.sv
// Controller: sequences renormalise, scale, flush and drain
`timescale 1ns / 1ps
module recb_ctrl import recb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_RN_TEST, S_RN_FH, S_RN_FR, S_RN_BYTE, S_RN_FOL,
		S_FACTOR, S_MLL, S_MLH, S_MDL, S_MDH, S_MEND,
		S_FIN_TEST, S_FIN_FH, S_FIN_FR, S_SH_INIT, S_SHORT, S_TAIL,
		S_DONE, S_DRAIN
	} state_t;

	state_t state_q, state_nxt;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_DRAIN);

	// Decode command and next state
	always_comb begin
		cmd = CMD_NOP;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: if (in_valid) begin
				cmd = CMD_LOAD;
				state_nxt = S_RN_TEST;
			end
			S_RN_TEST: begin
				if (!status.width_lt) state_nxt = S_FACTOR;
				else if (status.diff_zero) state_nxt = S_RN_FH;
				else state_nxt = S_RN_FOL;
			end
			S_RN_FH: begin
				cmd = CMD_FLUSH_HELD;
				state_nxt = S_RN_FR;
			end
			S_RN_FR: begin
				cmd = CMD_FLUSH_RUN;
				state_nxt = S_RN_BYTE;
			end
			S_RN_BYTE: begin
				if (status.diff_zero && status.width_lt) cmd = CMD_EMIT_TOP;
				else state_nxt = S_RN_FOL;
			end
			S_RN_FOL: begin
				if (status.width_lt) cmd = CMD_ADD_FOLLOW;
				else begin
					cmd = CMD_MASK;
					state_nxt = S_FACTOR;
				end
			end
			S_FACTOR: begin
				cmd = CMD_FACTOR;
				state_nxt = S_MLL;
			end
			S_MLL: begin
				cmd = CMD_MUL_LL;
				state_nxt = S_MLH;
			end
			S_MLH: begin
				cmd = CMD_MUL_LH;
				state_nxt = S_MDL;
			end
			S_MDL: begin
				cmd = CMD_MUL_DL;
				state_nxt = S_MDH;
			end
			S_MDH: begin
				cmd = CMD_MUL_DH;
				state_nxt = S_MEND;
			end
			S_MEND: begin
				cmd = CMD_MUL_END;
				state_nxt = status.eom ? S_FIN_TEST : S_DONE;
			end
			S_FIN_TEST: begin
				if (status.straddle) begin
					cmd = CMD_HELD_PLUS1;
					state_nxt = S_DONE;
				end else state_nxt = S_FIN_FH;
			end
			S_FIN_FH: begin
				cmd = CMD_FLUSH_HELD;
				state_nxt = S_FIN_FR;
			end
			S_FIN_FR: begin
				cmd = CMD_FLUSH_RUN;
				state_nxt = S_SH_INIT;
			end
			S_SH_INIT: begin
				cmd = CMD_SHORT_INIT;
				state_nxt = S_SHORT;
			end
			S_SHORT: begin
				cmd = CMD_SHORT_STEP;
				if (status.short_done) state_nxt = S_TAIL;
			end
			S_TAIL: begin
				if (status.tail_nz) cmd = CMD_TAIL;
				else state_nxt = S_DONE;
			end
			S_DONE: begin
				cmd = CMD_DONE;
				state_nxt = status.cnt_nz ? S_DRAIN : S_IDLE;
			end
			S_DRAIN: if (!out_stall) begin
				cmd = CMD_POP;
				if (status.last) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

endmodule

FILE: dv/range_encoder_byte_carry_test.sv
// Self-checking testbench for the byte range encoder with carry propagation
`timescale 1ns / 1ps
module range_encoder_byte_carry_test;
	import recb_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_word_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_data;
	logic       cfg_wr_en;
	logic [4:0] cfg_wr_data;

	range_encoder_byte_carry DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	localparam logic [56:0] WIDTH_FLOOR = 57'h1 << 40;
	localparam logic [56:0] BASE_MASK = (57'h1 << 56) - 1;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES = 300;

	// coder state of the predictor
	logic [56:0] enc_base = '0;
	logic [56:0] enc_width = 57'h1 << 56;
	logic [31:0] enc_follow = '0;
	logic [7:0]  enc_held = '0;
	logic        enc_ovf = 1'b0;
	logic [4:0]  enc_shift = 5'd16;

	out_word_t word_q[$];
	out_word_t expected_words[$];
	in_word_t  pending_words[$];

	int  fail_count = 0;
	int  cycle_count = 0;
	bit  hold_req = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void push_byte(logic [63:0] b, logic [63:0] rep);
		out_word_t w;
		if (word_q.size() >= 14) return;
		if (rep > 64'hFFFF_FFFF) begin
			rep = 64'hFFFF_FFFF;
			enc_ovf = 1;
		end
		w.out_byte = b[7:0];
		w.repeat_count = rep[31:0];
		w.run_end = 0;
		w.count_overflow = 0;
		word_q = {word_q, w};
	endfunction

	function automatic void release_follow(logic carry);
		if (enc_follow == 0) return;
		push_byte({56'h0, enc_held} + 64'(carry), 64'd1);
		if (enc_follow > 1)
			push_byte(carry ? 64'h00 : 64'hFF, 64'(enc_follow) - 64'd1);
		enc_follow = 0;
	endfunction

	function automatic void clear_coder();
		enc_base = 0;
		enc_width = 57'h1 << 56;
		enc_follow = 0;
		enc_held = 0;
		enc_ovf = 0;
	endfunction

	// work out the words one symbol produces
	function automatic void encode_symbol(in_word_t iw);
		logic [63:0] lo, hi, total, factor, top, v, cand, l64, h64;
		logic [63:0] base64, width64;
		int sh, nb, s;
		lo = 64'(iw.interval_low);
		hi = 64'(iw.interval_high);
		sh = int'(enc_shift);
		if (sh < 2) sh = 2;
		if (sh > 23) sh = 23;
		total = 64'h1 << sh;
		if (hi > total) hi = total;
		if (hi == 0) hi = 1;
		if (lo >= hi) lo = hi - 1;
		word_q.delete();
		base64 = 64'(enc_base);
		width64 = 64'(enc_width);
		// renormalise
		if (width64 < WIDTH_FLOOR) begin
			top = base64 + width64 - 1;
			if (((base64 ^ top) >> 48) == 0) begin
				release_follow(base64[56]);
				while (((base64 ^ (base64 + width64 - 1)) >> 48) == 0
						&& width64 < WIDTH_FLOOR) begin
					push_byte((base64 >> 48) & 64'hFF, 64'd1);
					base64 = (base64 << 8) & BASE_MASK;
					width64 = width64 << 8;
				end
			end
			while (width64 < WIDTH_FLOOR) begin
				if (enc_follow == 0) enc_held = base64[55:48];
				if (enc_follow == 32'hFFFF_FFFF) enc_ovf = 1;
				else enc_follow = enc_follow + 32'd1;
				base64 = base64 << 8;
				width64 = width64 << 8;
			end
			base64 = base64 & BASE_MASK;
		end
		factor = width64 >> sh;
		base64 = base64 + lo * factor;
		width64 = (hi - lo) * factor;
		// flush the tail
		if (iw.end_of_message) begin
			top = base64 + width64 - 1;
			if (((base64 ^ top) >> 56) & 1) begin
				if (enc_follow != 0) push_byte({56'h0, enc_held} + 64'd1, 64'd1);
			end else begin
				release_follow(base64[56]);
				l64 = base64 & BASE_MASK;
				h64 = top & BASE_MASK;
				cand = 0;
				for (s = 48; s >= 0; s -= 8) begin
					cand = cand + (((h64 >> s) & 64'hFF) << s);
					if (cand >= l64) break;
				end
				v = cand;
				nb = 7;
				while (nb > 0 && (v & 64'hFF) == 0) begin
					v = v >> 8;
					nb--;
				end
				for (int i = nb - 1; i >= 0; i--)
					push_byte((v >> (8 * i)) & 64'hFF, 64'd1);
			end
		end
		enc_base = base64[56:0];
		enc_width = width64[56:0];
		foreach (word_q[k]) begin
			word_q[k].run_end = (k == word_q.size() - 1);
			word_q[k].count_overflow = enc_ovf;
			expected_words = {expected_words, word_q[k]};
		end
		if (iw.end_of_message) clear_coder();
	endfunction

	function automatic void queue_item(in_word_t w);
		pending_words = {pending_words, w};
	endfunction

	// acceptance: predict the words and retire the offered item
	bit in_taken = 0;
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			encode_symbol(in_data);
			void'(pending_words.pop_front());
		end
	end

	// driver: offer the oldest pending item, idling a random gap after each accept
	int send_gap = 0;
	always @(negedge clk) begin
		int gap;
		gap = in_taken ? int'($urandom_range(0, 3)) : send_gap;
		if (!arst_n) begin
			send_gap <= 0;
			in_valid <= 1'b0;
		end else if (gap > 0) begin
			send_gap <= gap - 1;
			in_valid <= 1'b0;
		end else if (pending_words.size() > 0) begin
			send_gap <= 0;
			in_valid <= 1'b1;
			in_data <= pending_words[0];
		end else begin
			send_gap <= 0;
			in_valid <= 1'b0;
		end
	end

	// monitor: compare each word with the oldest expectation
	bit out_taken = 0;
	always @(posedge clk) begin
		out_word_t exp_w;
		out_taken <= arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t unexpected word: expected none, actual %h", $realtime, out_data);
				fail_count++;
			end else begin
				exp_w = expected_words.pop_front();
				if (out_data !== exp_w) begin
					$display("%0t mismatch: expected %h, actual %h",
						$realtime, exp_w, out_data);
					fail_count++;
				end
			end
		end
	end

	// receiver: random gap after each word, one long hold-off on request
	int recv_gap = 0;
	int hold_cnt = 0;
	always @(negedge clk) begin
		int gap;
		gap = out_taken ? int'($urandom_range(0, 3)) : recv_gap;
		if (hold_req && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			recv_gap <= 0;
			out_stall <= 1'b1;
		end else if (gap > 0) begin
			recv_gap <= gap - 1;
			out_stall <= 1'b1;
		end else begin
			recv_gap <= 0;
			out_stall <= 1'b0;
		end
	end

	function automatic in_word_t rand_symbol(int sh, bit eom);
		in_word_t w;
		int unsigned total, lo, hi;
		total = 1 << sh;
		lo = $urandom_range(0, total - 1);
		hi = $urandom_range(lo + 1, total);
		if ($urandom_range(0, 3) == 0) hi = lo + 1;
		w.interval_low = 23'(lo);
		w.interval_high = 24'(hi);
		w.end_of_message = eom;
		return w;
	endfunction

	function automatic in_word_t sym(int unsigned lo, int unsigned hi, bit eom);
		in_word_t w;
		w.interval_low = 23'(lo);
		w.interval_high = 24'(hi);
		w.end_of_message = eom;
		return w;
	endfunction

	task automatic wait_drained();
		while (pending_words.size() > 0 || expected_words.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_shift(logic [4:0] val);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en <= 0;
		enc_shift = val;
	endtask

	initial begin
		int shifts[6] = '{16, 2, 23, 0, 31, 8};
		int sh;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, clamped bounds, empty intervals, straddles
		queue_item(sym(0, 1, 0));
		queue_item(sym(0, 1, 0));
		queue_item(sym(0, 1, 0));
		queue_item(sym(65535, 65536, 0));
		queue_item(sym(65535, 65536, 0));
		queue_item(sym(32767, 32769, 0));
		queue_item(sym(32768, 32769, 0));
		queue_item(sym(0, 32768, 0));
		queue_item(sym(0, 0, 0));
		queue_item(sym(23'h7FFFFF, 24'hFFFFFF, 0));
		queue_item(sym(5000, 100, 0));
		queue_item(sym(0, 24'h800000, 1));
		queue_item(sym(0, 65536, 1));
		queue_item(sym(65535, 65536, 1));
		queue_item(sym(32767, 32769, 0));
		queue_item(sym(32767, 32769, 0));
		queue_item(sym(32767, 32769, 1));
		wait_drained();

		// random phases over several shift settings
		for (int p = 0; p < 6; p++) begin
			set_shift(5'(shifts[p]));
			sh = shifts[p] < 2 ? 2 : (shifts[p] > 23 ? 23 : shifts[p]);
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 9) == 0)
					queue_item(sym($urandom, $urandom, $urandom_range(0, 1) == 1));
				else
					queue_item(rand_symbol(sh, $urandom_range(0, 11) == 0));
				if (p == 2 && i == 10) begin
					// long receiver hold-off while items keep coming
					hold_req = 1;
					for (int j = 0; j < 20; j++)
						queue_item(rand_symbol(sh, 0));
				end
				if (i == 25) begin
					while (pending_words.size() > 0 || expected_words.size() > 0)
						@(posedge clk);
				end
				while (pending_words.size() > 4) @(posedge clk);
			end
			queue_item(rand_symbol(sh, 1));
			wait_drained();
		end
		repeat (60) @(posedge clk);
		if (fail_count == 0 && expected_words.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/recb_pkg.sv
rtl/recb_dpath.sv
rtl/recb_ctrl.sv
rtl/range_encoder_byte_carry.sv
dv/range_encoder_byte_carry_test.sv
